>>> rtl/core/assert_macros.svh
// Assertion macros shared by the rectangle upload RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VRU_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VRU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/vru_pkg.sv
// Shared types and constants of the rectangle upload writer.
// No dependencies; used by vru_cursor and vram_rect_upload_writer.
`default_nettype none

package vru_pkg;

	localparam int unsigned X_W     = 10;
	localparam int unsigned Y_W     = 9;
	localparam int unsigned PIX_W   = 16;
	localparam int unsigned CNT_W   = 20;
	localparam int unsigned WORDS_W = 19;

	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} opcode_t;

	typedef enum logic {
		KIND_ACK   = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	// Cursor commands from the transaction control.
	typedef struct packed {
		logic load;
		logic advance;
	} cur_ctrl_t;

	// Rectangle geometry taken on a start transaction.
	typedef struct packed {
		logic [X_W-1:0] x_wrap;   // origin column modulo memory width
		logic [Y_W-1:0] y_raw;    // origin row as given
		logic [Y_W-1:0] y_wrap;   // origin row modulo memory height
		logic [X_W-1:0] w_m1;     // rectangle width minus one
	} cur_load_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
	} cur_pos_t;

endpackage

`default_nettype wire

>>> rtl/core/vru_cursor.sv
// Row-major write cursor with wrapped column and row tracking.
// Depends on vru_pkg and assert_macros.svh.
`default_nettype none

module vru_cursor #(
	parameter int unsigned MEM_WIDTH  = 1024,
	parameter int unsigned MEM_HEIGHT = 512
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vru_pkg::cur_ctrl_t ctrl,
	input  wire vru_pkg::cur_load_t ld,
	output vru_pkg::cur_pos_t       pos
);

	`include "assert_macros.svh"

	localparam logic [vru_pkg::X_W-1:0] WX_MAX = vru_pkg::X_W'(MEM_WIDTH - 1);
	localparam logic [vru_pkg::Y_W-1:0] WY_MAX = vru_pkg::Y_W'(MEM_HEIGHT - 1);
	localparam logic [vru_pkg::Y_W-1:0] CY_MAX = '1;

	logic [vru_pkg::X_W-1:0] col_q;    // offset inside the row
	logic [vru_pkg::X_W-1:0] wm1_q;    // width minus one
	logic [vru_pkg::X_W-1:0] wx_q;     // wrapped column
	logic [vru_pkg::X_W-1:0] rsx_q;    // wrapped row start column
	logic [vru_pkg::Y_W-1:0] cy_q;     // row, wraps on 9 bits
	logic [vru_pkg::Y_W-1:0] wy_q;     // wrapped row

	logic row_end;
	assign row_end = (col_q == wm1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			wm1_q <= '0;
			wx_q  <= '0;
			rsx_q <= '0;
			cy_q  <= '0;
			wy_q  <= '0;
		end else if (ctrl.load) begin
			col_q <= '0;
			wm1_q <= ld.w_m1;
			wx_q  <= ld.x_wrap;
			rsx_q <= ld.x_wrap;
			cy_q  <= ld.y_raw;
			wy_q  <= ld.y_wrap;
		end else if (ctrl.advance) begin
			if (row_end) begin
				col_q <= '0;
				wx_q  <= rsx_q;
				cy_q  <= cy_q + 1'b1;
				if (cy_q == CY_MAX || wy_q == WY_MAX) begin
					wy_q <= '0;
				end else begin
					wy_q <= wy_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
				wx_q  <= (wx_q == WX_MAX) ? '0 : wx_q + 1'b1;
			end
		end
	end

	assign pos.x = wx_q;
	assign pos.y = wy_q;

	`VRU_ASSERT(a_col_in_row, 1'b1, col_q <= wm1_q, "cursor column beyond rectangle width")
	`VRU_ASSERT(a_wx_range, 1'b1, 11'(wx_q) < 11'(MEM_WIDTH), "wrapped column out of range")
	`VRU_ASSERT(a_wy_range, 1'b1, 10'(wy_q) < 10'(MEM_HEIGHT), "wrapped row out of range")

endmodule

`default_nettype wire

>>> rtl/core/vram_rect_upload_writer.sv
// Rectangle upload writer: start/data transactions in, pixel writes out.
// Depends on vru_pkg, vru_cursor and assert_macros.svh.
//
//  channel | dir | tdata                                  | tuser  | tlast
//  --------+-----+----------------------------------------+--------+------
//  s_*     | in  | origin_x, origin_y, size_w, size_h, wd  | opcode | -
//  m_*     | out | write_x, write_y, pixel, done, count    | kind   | last
//
// A start transaction yields one acknowledgement.
// A data word yields two pixels, one after the other through the single output register.
// A data word while idle is dropped with no result.
// Reset clears the pipeline valid bits, the transfer state and the cursor.
// A stalled m_tready holds the output register; the input register then fills
// and s_tready drops until the pending result moves.
`default_nettype none

module vram_rect_upload_writer #(
	parameter int unsigned MEM_WIDTH  = 1024,
	parameter int unsigned MEM_HEIGHT = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [9:0] origin_x, [18:10] origin_y, [34:19] size_w_field,
	// [50:35] size_h_field, [82:51] data_word, [87:83] zero
	input  wire logic [87:0] s_tdata,
	// [0] opcode
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [9:0] write_x, [18:10] write_y, [34:19] pixel_value,
	// [35] transfer_done, [55:36] halfword_count
	output logic [55:0]      m_tdata,
	// [0] kind
	output logic [0:0]       m_tuser,
	output logic             m_tlast
);

	`include "assert_macros.svh"

	localparam int unsigned X_W = vru_pkg::X_W;
	localparam int unsigned Y_W = vru_pkg::Y_W;
	localparam int unsigned P_W = vru_pkg::PIX_W;
	localparam int unsigned C_W = vru_pkg::CNT_W;
	localparam int unsigned N_W = vru_pkg::WORDS_W;

	// Reciprocals for the origin wrap: the estimated quotient is exact or one low.
	localparam int unsigned RECIP_X = (1 << 20) / MEM_WIDTH;
	localparam int unsigned RECIP_Y = (1 << 18) / MEM_HEIGHT;
	localparam logic [15:0] MW16    = 16'(MEM_WIDTH);
	localparam logic [15:0] MH16    = 16'(MEM_HEIGHT);

	// ---------------------------------------------------------------
	// Input side: decode size, form the area product and the wrap quotients.
	// ---------------------------------------------------------------
	logic [X_W-1:0] in_ox;
	logic [Y_W-1:0] in_oy;
	logic [X_W-1:0] in_wm1;
	logic [Y_W-1:0] in_hm1;
	logic [C_W-1:0] in_area;
	logic [26:0]    in_px;
	logic [26:0]    in_py;

	assign in_ox   = s_tdata[9:0];
	assign in_oy   = s_tdata[18:10];
	// zero in the size field means the maximum: subtract one, keep the low bits
	assign in_wm1  = s_tdata[28:19] - 10'd1;
	assign in_hm1  = s_tdata[43:35] - 9'd1;
	assign in_area = (C_W'(in_wm1) + 1'b1) * (C_W'(in_hm1) + 1'b1);
	assign in_px   = 27'(in_ox) * 27'(RECIP_X);
	assign in_py   = 27'(in_oy) * 27'(RECIP_Y);

	// Input register stage.
	logic                 valid_s1;
	vru_pkg::opcode_t     op_s1;
	logic [X_W-1:0]       ox_s1;
	logic [Y_W-1:0]       oy_s1;
	logic [X_W-1:0]       wm1_s1;
	logic [C_W-1:0]       area_s1;
	logic [5:0]           qx_s1;
	logic [5:0]           qy_s1;
	logic [31:0]          word_s1;

	// Transfer state.
	logic                 active_q;
	logic                 phase_q;     // high half of the word is next
	logic                 done_q;      // held for the second pixel
	logic [N_W-1:0]       words_exp_q;
	logic [N_W-1:0]       words_rcv_q;

	// Output register.
	logic                 out_valid_q;
	vru_pkg::kind_t       out_kind_q;
	logic [X_W-1:0]       out_x_q;
	logic [Y_W-1:0]       out_y_q;
	logic [P_W-1:0]       out_pix_q;
	logic                 out_last_q;
	logic                 out_done_q;
	logic [C_W-1:0]       out_cnt_q;

	// ---------------------------------------------------------------
	// Control
	// ---------------------------------------------------------------
	logic           can_emit;
	logic           is_start;
	logic           drop;
	logic           emit;
	logic           s1_free;
	logic [N_W-1:0] rcv_next;
	logic           done_now;
	logic           done_sel;
	logic [C_W-1:0] area_p1;
	logic [C_W-1:0] count;

	assign can_emit = !out_valid_q || m_tready;
	assign is_start = valid_s1 && (op_s1 == vru_pkg::OP_START);
	// ignore data while no transfer runs
	assign drop     = valid_s1 && (op_s1 == vru_pkg::OP_DATA) && !active_q && !phase_q;
	assign emit     = valid_s1 && !drop && can_emit;
	assign s1_free  = drop || (emit && (is_start || phase_q));
	assign s_tready = !valid_s1 || s1_free;

	assign rcv_next = words_rcv_q + 1'b1;
	assign done_now = (rcv_next == words_exp_q);
	assign done_sel = phase_q ? done_q : done_now;

	// round the area up to even
	assign area_p1  = area_s1 + 1'b1;
	assign count    = {area_p1[C_W-1:1], 1'b0};

	// Finish the origin wrap: remainder of the estimate, corrected once.
	logic [15:0] rx_est;
	logic [15:0] ry_est;
	logic [15:0] rx_fix;
	logic [15:0] ry_fix;

	assign rx_est = 16'(ox_s1) - 16'(qx_s1) * MW16;
	assign ry_est = 16'(oy_s1) - 16'(qy_s1) * MH16;
	assign rx_fix = (rx_est >= MW16) ? rx_est - MW16 : rx_est;
	assign ry_fix = (ry_est >= MH16) ? ry_est - MH16 : ry_est;

	vru_pkg::cur_ctrl_t cur_ctrl;
	vru_pkg::cur_load_t cur_ld;
	vru_pkg::cur_pos_t  cur_pos;

	assign cur_ctrl.load    = emit && is_start;
	assign cur_ctrl.advance = emit && !is_start;
	assign cur_ld.x_wrap    = rx_fix[X_W-1:0];
	assign cur_ld.y_raw     = oy_s1;
	assign cur_ld.y_wrap    = ry_fix[Y_W-1:0];
	assign cur_ld.w_m1      = wm1_s1;

	vru_cursor #(
		.MEM_WIDTH  (MEM_WIDTH),
		.MEM_HEIGHT (MEM_HEIGHT)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cur_ctrl),
		.ld     (cur_ld),
		.pos    (cur_pos)
	);

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload of the input stage: load on every accepted transaction
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= vru_pkg::opcode_t'(s_tuser[0]);
			ox_s1   <= in_ox;
			oy_s1   <= in_oy;
			wm1_s1  <= in_wm1;
			area_s1 <= in_area;
			qx_s1   <= in_px[25:20];
			qy_s1   <= in_py[23:18];
			word_s1 <= s_tdata[82:51];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= 1'b0;
			done_q      <= 1'b0;
			words_exp_q <= '0;
			words_rcv_q <= '0;
		end else if (emit) begin
			if (is_start) begin
				// a start abandons any running transfer
				active_q    <= 1'b1;
				phase_q     <= 1'b0;
				words_exp_q <= area_p1[C_W-1:1];
				words_rcv_q <= '0;
			end else if (!phase_q) begin
				phase_q     <= 1'b1;
				done_q      <= done_now;
				words_rcv_q <= rcv_next;
				if (done_now) begin
					active_q <= 1'b0;
				end
			end else begin
				phase_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (is_start) begin
				out_kind_q <= vru_pkg::KIND_ACK;
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_pix_q  <= '0;
				out_last_q <= 1'b1;
				out_done_q <= 1'b0;
				out_cnt_q  <= count;
			end else begin
				out_kind_q <= vru_pkg::KIND_PIXEL;
				out_x_q    <= cur_pos.x;
				out_y_q    <= cur_pos.y;
				out_pix_q  <= phase_q ? word_s1[31:16] : word_s1[15:0];
				out_last_q <= phase_q;
				out_done_q <= done_sel;
				out_cnt_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_cnt_q, out_done_q, out_pix_q, out_y_q, out_x_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`VRU_ASSERT(a_phase_on_data, phase_q, valid_s1 && op_s1 == vru_pkg::OP_DATA,
		"second pixel pending without a data word")
	`VRU_ASSERT(a_rcv_below_exp, active_q, words_rcv_q < words_exp_q,
		"active transfer already received all words")
	`VRU_ASSERT_NEXT(a_start_arms, emit && is_start, active_q && !phase_q,
		"start did not arm the transfer")
	`VRU_ASSERT(a_ack_is_last, out_valid_q && out_kind_q == vru_pkg::KIND_ACK, out_last_q,
		"acknowledgement not marked last")

endmodule

`default_nettype wire

>>> dv/vru_upload_checker.sv
// Scoreboard for the rectangle upload writer: watches both stream channels,
// predicts the result transactions and compares them field by field.
// Depends on vru_pkg for the opcode and kind codes and the field widths.
`default_nettype none

module vru_upload_checker
	import vru_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [87:0] s_tdata,
	input  wire logic [0:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata,
	input  wire logic [0:0]  m_tuser,
	input  wire logic        m_tlast,
	output int               error_count,
	output int               pending
);

	localparam int unsigned MEM_W      = 1024;
	localparam int unsigned MEM_H      = 512;

	typedef struct {
		kind_t              kind;
		logic [X_W-1:0]     wx;
		logic [Y_W-1:0]     wy;
		logic [PIX_W-1:0]   pix;
		logic               last;
		logic               done;
		logic [CNT_W-1:0]   count;
	} upload_beat_t;

	upload_beat_t predicted_beats[$];

	// transfer state as the block should hold it
	bit                 xfer_active = 1'b0;
	logic [10:0]        cur_x       = '0;
	logic [X_W-1:0]     row_x       = '0;
	logic [Y_W-1:0]     cur_y       = '0;
	logic [10:0]        rect_w      = 11'd1;
	logic [WORDS_W-1:0] words_exp   = '0;
	logic [WORDS_W-1:0] words_rcv   = '0;

	// row-major step inside the rectangle; the row after the last one is allowed
	task automatic step_cursor();
		logic [10:0] offset;
		offset = cur_x - {1'b0, row_x};
		if (offset == rect_w - 11'd1) begin
			cur_x = {1'b0, row_x};
			cur_y = cur_y + 1'b1;
		end else begin
			cur_x = cur_x + 11'd1;
		end
	endtask

	task automatic predict_upload_step(input opcode_t op, input logic [87:0] d);
		logic [9:0]       wm1;
		logic [8:0]       hm1;
		logic [10:0]      w;
		logic [9:0]       h;
		logic [CNT_W-1:0] cnt;
		logic [PIX_W-1:0] px[2];
		logic             done;
		upload_beat_t     b;
		if (op == OP_START) begin
			// zero in the low size bits means the full memory extent
			wm1 = d[28:19] - 10'd1;
			hm1 = d[43:35] - 9'd1;
			w = {1'b0, wm1} + 11'd1;
			h = {1'b0, hm1} + 10'd1;
			cnt = (20'(w) * 20'(h) + 20'd1) & ~20'd1;
			cur_x = {1'b0, d[9:0]};
			row_x = d[9:0];
			cur_y = d[18:10];
			rect_w = w;
			words_exp = cnt[CNT_W-1:1];
			words_rcv = '0;
			xfer_active = 1'b1;
			b = '{KIND_ACK, '0, '0, '0, 1'b1, 1'b0, cnt};
			predicted_beats.insert(predicted_beats.size(), b);
		end else if (xfer_active) begin
			px[0] = d[66:51];
			px[1] = d[82:67];
			words_rcv = words_rcv + 1'b1;
			done = (words_rcv == words_exp);
			for (int i = 0; i < 2; i++) begin
				b = '{KIND_PIXEL, X_W'(cur_x % MEM_W), Y_W'(cur_y % MEM_H), px[i],
					i == 1, done, '0};
				predicted_beats.insert(predicted_beats.size(), b);
				step_cursor();
			end
			if (done)
				xfer_active = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		upload_beat_t e;
		if (!arst_n) begin
			xfer_active = 1'b0;
			cur_x = '0;
			row_x = '0;
			cur_y = '0;
			rect_w = 11'd1;
			words_exp = '0;
			words_rcv = '0;
			predicted_beats.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_upload_step(opcode_t'(s_tuser), s_tdata);
			if (m_tvalid && m_tready) begin
				if (predicted_beats.size() == 0) begin
					error_count++;
					$display("%0t: result with nothing expected, expected none, actual %0h/%0h",
						$time, m_tuser, m_tdata);
				end else begin
					e = predicted_beats.pop_front();
					check_field("kind", e.kind, m_tuser);
					check_field("write_x", e.wx, m_tdata[9:0]);
					check_field("write_y", e.wy, m_tdata[18:10]);
					check_field("pixel_value", e.pix, m_tdata[34:19]);
					check_field("transfer_done", e.done, m_tdata[35]);
					check_field("halfword_count", e.count, m_tdata[55:36]);
					check_field("last", e.last, m_tlast);
				end
			end
			pending <= predicted_beats.size();
		end
	end

endmodule

`default_nettype wire

>>> dv/tb_vram_rect_upload_writer.sv
// Testbench top for the rectangle upload writer: clock, reset, stimulus and verdict.
// Depends on vru_pkg, vram_rect_upload_writer and vru_upload_checker.
`default_nettype none

module tb_vram_rect_upload_writer;
	import vru_pkg::*;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [9:0] origin_x, [18:10] origin_y, [34:19] size_w_field,
	// [50:35] size_h_field, [82:51] data_word, [87:83] zero
	logic [87:0] s_tdata  = '0;
	// [0] opcode
	logic [0:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [9:0] write_x, [18:10] write_y, [34:19] pixel_value,
	// [35] transfer_done, [55:36] halfword_count
	logic [55:0] m_tdata;
	// [0] kind
	logic [0:0]  m_tuser;
	logic        m_tlast;

	int error_count;
	int pending;

	// Idle percentages per side; the receiver's is read in its own process.
	int tx_idle_pct = 18;
	int rx_idle_pct = 71;

	// Long receiver hold-off: requested by the stimulus, timed by the receiver.
	logic hold_req   = 1'b0;
	bit   hold_taken = 1'b0;
	int   hold_left  = 0;

	// Stimulus bookkeeping: words still owed to the open transfer, and the
	// number of transactions the block acts on (ignored data is not counted).
	logic [WORDS_W-1:0] open_words = '0;
	int                 item_count = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	vram_rect_upload_writer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	vru_upload_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.error_count (error_count),
		.pending     (pending)
	);

	// Receiver: random stalls, plus one long hold-off while the sender keeps
	// offering, so the output register and then the input register fill up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			m_tready <= 1'b0;
			hold_left <= 400;
			hold_taken <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Offer one transaction after a random gap and hold it until accepted.
	// Drive on the rising edge; s_tvalid stays high when no gap follows.
	task automatic push_item(input opcode_t op, input logic [9:0] ox, input logic [8:0] oy,
			input logic [15:0] wf, input logic [15:0] hf, input logic [31:0] wd);
		logic [9:0]  wm1;
		logic [8:0]  hm1;
		logic [19:0] area;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, wd, hf, wf, oy, ox};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// track how many data words the block will still take
		if (op == OP_START) begin
			wm1 = wf[9:0] - 10'd1;
			hm1 = hf[8:0] - 9'd1;
			area = (20'(wm1) + 20'd1) * (20'(hm1) + 20'd1);
			open_words = WORDS_W'((area + 20'd1) >> 1);
			item_count++;
		end else if (open_words != 0) begin
			open_words--;
			item_count++;
		end
	endtask

	// Data transaction with every field random; only data_word matters.
	task automatic push_random_word();
		push_item(OP_DATA, 10'($urandom), 9'($urandom), 16'($urandom), 16'($urandom),
			$urandom());
	endtask

	// Complete transfer: start with the decoded size w x h (junk in the unused
	// size bits), then exactly the word count it calls for.
	task automatic run_upload(input logic [9:0] ox, input logic [8:0] oy, input int w,
			input int h);
		logic [10:0] wv;
		logic [9:0]  hv;
		wv = 11'(w);
		hv = 10'(h);
		push_item(OP_START, ox, oy, {6'($urandom), wv[9:0]}, {7'($urandom), hv[8:0]},
			$urandom());
		while (open_words != 0)
			push_random_word();
	endtask

	initial begin
		int pick;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: data while idle, all ones on every field; drop it.
		push_item(OP_DATA, '1, '1, '1, '1, 32'hFFFF_FFFF);
		// Zero size fields decode to the full memory; abandon after two words.
		push_item(OP_START, '0, '0, 16'h0000, 16'h0000, 32'h0000_0000);
		push_item(OP_DATA, '0, '0, '0, '0, 32'h0000_0000);
		push_item(OP_DATA, '0, '0, '0, '0, 32'hFFFF_0000);
		// All-ones start while active: the running transfer is replaced.
		push_item(OP_START, 10'h3FF, 9'h1FF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		push_item(OP_DATA, '1, '1, '1, '1, 32'h0000_FFFF);
		// Odd count at the far corner: wraps in x and y, padding pixel on the
		// row below the rectangle.
		run_upload(10'd1022, 9'd510, 3, 3);
		// Smallest rectangle; padding pixel lands one row down.
		run_upload(10'd0, 9'd0, 1, 1);
		// Data after the transfer finished; drop it.
		push_random_word();
		// Even count wrapping in x only.
		run_upload(10'd1023, 9'd0, 2, 2);

		// Random: mostly complete transfers of small rectangles, some cut short
		// by a new start, some stray data words.
		while (item_count < 900) begin
			if (item_count >= 600) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end else if (item_count >= 300) begin
				tx_idle_pct = 71;
				rx_idle_pct <= 18;
			end
			if (item_count >= 150)
				hold_req <= 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if ($urandom_range(0, 3) == 0)
					run_upload(10'($urandom_range(1016, 1023)), 9'($urandom_range(505, 511)),
						$urandom_range(1, 12), $urandom_range(1, 6));
				else
					run_upload(10'($urandom), 9'($urandom), $urandom_range(1, 12),
						$urandom_range(1, 6));
			end else if (pick < 71) begin
				// one long row, wrapping in x for most origins
				run_upload(10'($urandom), 9'($urandom), $urandom_range(17, 1024), 1);
			end else if (pick < 86) begin
				push_item(OP_START, 10'($urandom), 9'($urandom), 16'($urandom), 16'($urandom),
					$urandom());
				repeat ($urandom_range(0, 3))
					push_random_word();
			end else begin
				repeat ($urandom_range(1, 3))
					push_random_word();
			end
		end
		s_tvalid <= 1'b0;

		// Drain: let the last acceptance reach the checker, wait for every
		// expected result, then give any stray result time to appear.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
